// ----- design/adpm_pkg.sv -----
// Shared types and constants of the approximate DNA pattern matcher.
package adpm_pkg;

    localparam int MAX_PATTERN       = 24;
    localparam int MAX_ERRORS        = 7;
    localparam int NUM_SYMBOLS       = 5;
    localparam int POSITION_BITS     = 16;
    localparam int MASK_BITS         = 5;
    localparam int POSITIONS_PER_REG = 12;

    localparam int ROWS       = MAX_ERRORS + 1;
    localparam int SYM_W      = 3;
    localparam int SYM_CODES  = 1 << SYM_W;
    localparam int LEN_W      = 5;
    localparam int ERR_W      = 3;
    localparam int DIST_W     = 4;
    localparam int MASK_REG_W = MASK_BITS * POSITIONS_PER_REG;
    localparam int CFG_IDX_W  = 2;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    localparam logic [LEN_W-1:0]  PATTERN_LENGTH_RESET = LEN_W'(1);
    localparam logic [ERR_W-1:0]  MAX_ERRORS_RESET     = ERR_W'(0);
    localparam logic [DIST_W-1:0] BEST_RESET = DIST_W'(MAX_ERRORS_RESET) + DIST_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASKS_LOW      = 2'd0,
        CFG_MASKS_HIGH     = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2,
        CFG_MAX_ERRORS     = 2'd3
    } cfg_index_t;

    // item between the cell stage and the streak stage
    typedef struct packed {
        logic              line_start;
        logic [DIST_W-1:0] distance;
    } stage_item_t;

    typedef struct packed {
        logic [DIST_W-1:0]        distance_now;
        logic                     match_found;
        logic [POSITION_BITS-1:0] match_end;
        logic [POSITION_BITS-1:0] plateau_length;
        logic [ERR_W-1:0]         match_distance;
    } result_t;

endpackage

// ----- design/adpm_cells.sv -----
// Bit-parallel Levenshtein automaton cell array and final-column distance.
module adpm_cells
    import adpm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [SYM_W-1:0]      symbol,
    input  logic                  line_start,
    input  logic [MASK_REG_W-1:0] masks_low,
    input  logic [MASK_REG_W-1:0] masks_high,
    input  logic [LEN_W-1:0]      pattern_length,
    input  logic [ERR_W-1:0]      max_errors,
    output logic [DIST_W-1:0]     distance
);

    logic [ROWS-1:0] active_cells_reg  [0:MAX_PATTERN];
    logic [ROWS-1:0] active_cells_next [0:MAX_PATTERN];
    logic [ROWS-1:0] cur   [0:MAX_PATTERN];
    logic [ROWS-1:0] stay  [0:MAX_PATTERN];
    logic [ROWS-1:0] move  [0:MAX_PATTERN];
    logic [ROWS-1:0] nxt0  [0:MAX_PATTERN];

    logic [2*MASK_REG_W-1:0] masks_all;
    logic [SYM_CODES-1:0]    pos_mask;
    logic [ROWS-1:0]         rowmask;
    logic [ROWS-1:0]         fin;
    logic [ROWS-1:0]         shifted;
    logic [ROWS-1:0]         grown;
    logic [LEN_W-1:0]        len_used;
    logic [DIST_W-1:0]       rows;
    logic                    hit;

    assign masks_all = {masks_high, masks_low};
    assign rows      = DIST_W'(max_errors) + DIST_W'(1);

    always_comb
    begin
        pos_mask = '0;
        hit      = 1'b0;
        shifted  = '0;
        grown    = '0;

        if (pattern_length == '0)
            len_used = LEN_W'(1);
        else if (int'(pattern_length) > MAX_PATTERN)
            len_used = LEN_W'(MAX_PATTERN);
        else
            len_used = pattern_length;

        for (int r = 0; r < ROWS; r++)
            rowmask[r] = (r <= int'(max_errors));

        // current cells, line clear, start diagonal re-injected
        for (int c = 0; c <= MAX_PATTERN; c++)
        begin
            cur[c] = '0;
            if (c <= int'(len_used) && !line_start)
                cur[c] = active_cells_reg[c] & rowmask;
            if (c < ROWS && c <= int'(len_used) && c <= int'(max_errors))
                cur[c][c] = 1'b1;
        end

        // advance on the symbol; the final column is never advanced
        for (int c = 0; c <= MAX_PATTERN; c++)
        begin
            stay[c] = '0;
            move[c] = '0;
            if (c < MAX_PATTERN && c < int'(len_used))
            begin
                if (c < 2 * POSITIONS_PER_REG)
                    pos_mask = SYM_CODES'(masks_all[c*MASK_BITS +: MASK_BITS]);
                else
                    pos_mask = '0;
                hit = (int'(symbol) < NUM_SYMBOLS) && pos_mask[symbol];
                if (hit)
                    move[c] = cur[c];
                else
                begin
                    shifted = (cur[c] << 1) & rowmask;
                    stay[c] = shifted;
                    move[c] = shifted;
                end
            end
        end

        for (int c = 0; c <= MAX_PATTERN; c++)
        begin
            nxt0[c] = stay[c];
            if (c > 0)
                nxt0[c] = nxt0[c] | move[c-1];
        end

        // deletion closure: column c collects column c-k shifted down k rows
        for (int c = 0; c <= MAX_PATTERN; c++)
        begin
            active_cells_next[c] = '0;
            if (c <= int'(len_used))
            begin
                for (int k = 0; k < ROWS; k++)
                begin
                    if (k <= c)
                    begin
                        grown = (nxt0[c-k] << k) & rowmask;
                        active_cells_next[c] = active_cells_next[c] | grown;
                    end
                end
            end
        end

        fin      = active_cells_next[len_used] & rowmask;
        distance = rows;
        for (int r = ROWS - 1; r >= 0; r--)
        begin
            if (fin[r])
                distance = DIST_W'(r);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c <= MAX_PATTERN; c++)
                active_cells_reg[c] <= '0;
        end
        else if (accept)
        begin
            for (int c = 0; c <= MAX_PATTERN; c++)
                active_cells_reg[c] <= active_cells_next[c];
        end
    end

endmodule

// ----- design/adpm_streak.sv -----
// Best-distance streak tracker and result register.
module adpm_streak
    import adpm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  stage_item_t      item,
    input  logic [ERR_W-1:0] max_errors,
    output result_t          result
);

    logic [DIST_W-1:0]        best_distance_reg, best_distance_next;
    logic [POSITION_BITS-1:0] streak_start_reg, streak_start_next;
    logic                     after_report_reg, after_report_next;
    logic [POSITION_BITS-1:0] line_position_reg, line_position_next;
    result_t                  result_reg, result_next;

    logic [DIST_W-1:0]        best;
    logic [POSITION_BITS-1:0] start;
    logic                     after;
    logic [POSITION_BITS-1:0] pos;
    logic [POSITION_BITS-1:0] end_pos;

    always_comb
    begin
        if (item.line_start)
        begin
            best  = DIST_W'(max_errors) + DIST_W'(1);
            start = '0;
            after = 1'b0;
            pos   = '0;
        end
        else
        begin
            best  = best_distance_reg;
            start = streak_start_reg;
            after = after_report_reg;
            pos   = line_position_reg;
        end

        best_distance_next = best;
        streak_start_next  = start;
        after_report_next  = after;
        end_pos            = '0;
        result_next        = '0;
        result_next.distance_now = item.distance;

        if (item.distance < best)
        begin
            streak_start_next  = pos;
            best_distance_next = item.distance;
            after_report_next  = 1'b0;
        end
        else if (item.distance > best)
        begin
            if (after)
            begin
                streak_start_next  = pos;
                best_distance_next = item.distance;
            end
            else
            begin
                if (pos == POS_MAX)
                    end_pos = POS_MAX;
                else if (pos != '0)
                    end_pos = pos - POSITION_BITS'(1);
                else
                    end_pos = '0;
                result_next.match_found    = 1'b1;
                result_next.match_end      = end_pos;
                result_next.plateau_length = (end_pos >= start) ? end_pos - start : '0;
                result_next.match_distance = best[ERR_W-1:0];
                after_report_next          = 1'b1;
            end
        end

        line_position_next = (pos != POS_MAX) ? pos + POSITION_BITS'(1) : pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_distance_reg <= BEST_RESET;
            streak_start_reg  <= '0;
            after_report_reg  <= 1'b0;
            line_position_reg <= '0;
        end
        else if (advance)
        begin
            best_distance_reg <= best_distance_next;
            streak_start_reg  <= streak_start_next;
            after_report_reg  <= after_report_next;
            line_position_reg <= line_position_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// ----- design/approximate_dna_pattern_matcher_top.sv -----
// Top level of the approximate DNA pattern matcher: config, handshake, stages.
//
// Input channel (in_valid/in_ready) takes one base symbol per item, with
// line_start marking the first symbol of a line. Output channel
// (out_valid/out_ready) returns one result item per input item, in order.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write
// only while no item is in flight.
// Pipeline: an accepted item is registered in the middle stage, then in
// the result register (two register stages: automaton cells, then the
// streak tracker and result register).
// Throughput: one item per cycle while out_ready does not stall it, set
// by the active-cell grid update, which feeds back on itself every item.
// Reset: config and control registers take their defaults (pattern length 1,
// no errors, empty automaton); in_ready is high as soon as reset ends.
// Stall: when out_ready is low the result holds, the middle stage fills and
// in_ready then drops until the receiver takes the result.
module approximate_dna_pattern_matcher_top
    import adpm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [SYM_W-1:0]         symbol,
    input  logic                     line_start,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [DIST_W-1:0]        distance_now,
    output logic                     match_found,
    output logic [POSITION_BITS-1:0] match_end,
    output logic [POSITION_BITS-1:0] plateau_length,
    output logic [ERR_W-1:0]         match_distance,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [MASK_REG_W-1:0]    cfg_data
);

    logic [MASK_REG_W-1:0] masks_low_reg;
    logic [MASK_REG_W-1:0] masks_high_reg;
    logic [LEN_W-1:0]      pattern_length_reg;
    logic [ERR_W-1:0]      max_errors_reg;

    logic        s1_valid_reg;
    stage_item_t s1_item_reg;
    logic        out_valid_reg;

    logic              in_accept;
    logic              s1_advance;
    logic [DIST_W-1:0] distance;
    result_t           result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            masks_low_reg      <= '0;
            masks_high_reg     <= '0;
            pattern_length_reg <= PATTERN_LENGTH_RESET;
            max_errors_reg     <= MAX_ERRORS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MASKS_LOW:      masks_low_reg      <= cfg_data;
                CFG_MASKS_HIGH:     masks_high_reg     <= cfg_data;
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                CFG_MAX_ERRORS:     max_errors_reg     <= cfg_data[ERR_W-1:0];
            endcase
        end
    end

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_accept || (s1_valid_reg && !s1_advance);
            out_valid_reg <= s1_advance || (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg.line_start <= line_start;
            s1_item_reg.distance   <= distance;
        end
    end

    adpm_cells u_cells (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (in_accept),
        .symbol         (symbol),
        .line_start     (line_start),
        .masks_low      (masks_low_reg),
        .masks_high     (masks_high_reg),
        .pattern_length (pattern_length_reg),
        .max_errors     (max_errors_reg),
        .distance       (distance)
    );

    adpm_streak u_streak (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (s1_advance),
        .item       (s1_item_reg),
        .max_errors (max_errors_reg),
        .result     (result)
    );

    assign out_valid      = out_valid_reg;
    assign distance_now   = result.distance_now;
    assign match_found    = result.match_found;
    assign match_end      = result.match_end;
    assign plateau_length = result.plateau_length;
    assign match_distance = result.match_distance;

endmodule

// ----- tb/sv/approximate_dna_pattern_matcher_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the approximate DNA pattern matcher top level.
module approximate_dna_pattern_matcher_top_tb;
    import adpm_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PRINT_CAP      = 50;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [SYM_W-1:0]         symbol = '0;
    logic                     line_start = 1'b0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [DIST_W-1:0]        distance_now;
    logic                     match_found;
    logic [POSITION_BITS-1:0] match_end;
    logic [POSITION_BITS-1:0] plateau_length;
    logic [ERR_W-1:0]         match_distance;
    logic                     cfg_we = 1'b0;
    cfg_index_t               cfg_index = CFG_MASKS_LOW;
    logic [MASK_REG_W-1:0]    cfg_data = '0;

    approximate_dna_pattern_matcher_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .symbol         (symbol),
        .line_start     (line_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .distance_now   (distance_now),
        .match_found    (match_found),
        .match_end      (match_end),
        .plateau_length (plateau_length),
        .match_distance (match_distance),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor copy of registers and line state
    logic [MASK_REG_W-1:0]    m_lo;
    logic [MASK_REG_W-1:0]    m_hi;
    logic [LEN_W-1:0]         m_len;
    logic [ERR_W-1:0]         m_err;
    logic [ROWS-1:0]          cell_rows [0:MAX_PATTERN];
    logic [DIST_W-1:0]        best;
    logic [POSITION_BITS-1:0] run_start;
    logic [POSITION_BITS-1:0] line_pos;
    logic                     reported;

    result_t pending_reports [$];
    int      mismatch_count = 0;
    int      bases_sent = 0;
    int      stalled_cycles = 0;
    int      stall_left = 0;
    bit      idle_on = 1'b0;

    function automatic logic [MASK_BITS-1:0] pos_mask(input int p);
        if (p < POSITIONS_PER_REG)
            return m_lo[MASK_BITS*p +: MASK_BITS];
        if (p < 2*POSITIONS_PER_REG)
            return m_hi[MASK_BITS*(p-POSITIONS_PER_REG) +: MASK_BITS];
        return '0;
    endfunction

    function automatic int used_len();
        if (m_len == 0)
            return 1;
        if (m_len > MAX_PATTERN)
            return MAX_PATTERN;
        return int'(m_len);
    endfunction

    function automatic void restart_line();
        for (int c = 0; c <= MAX_PATTERN; c++)
            cell_rows[c] = '0;
        best      = DIST_W'(m_err) + DIST_W'(1);
        run_start = '0;
        reported  = 1'b0;
        line_pos  = '0;
    endfunction

    function automatic void reset_predictor();
        m_lo  = '0;
        m_hi  = '0;
        m_len = PATTERN_LENGTH_RESET;
        m_err = MAX_ERRORS_RESET;
        restart_line();
    endfunction

    // one automaton step plus the best-distance streak tracker
    function automatic result_t advance_levenshtein(input logic [SYM_W-1:0] sym,
                                                    input logic ls);
        int                       rows;
        int                       rmask;
        int                       len;
        int                       cur [0:MAX_PATTERN];
        int                       nxt [0:MAX_PATTERN];
        int                       a;
        int                       e;
        int                       fin;
        int                       distance;
        logic [MASK_BITS-1:0]     pm;
        logic                     hit;
        logic [POSITION_BITS-1:0] end_pos;
        result_t                  r;

        if (ls)
            restart_line();
        rows  = int'(m_err) + 1;
        rmask = (1 << rows) - 1;
        len   = used_len();
        for (int c = 0; c <= MAX_PATTERN; c++)
        begin
            cur[c] = 0;
            nxt[c] = 0;
        end
        for (int c = 0; c <= len; c++)
            cur[c] = int'(cell_rows[c]) & rmask;
        // start diagonal re-injected every step
        for (int q = 0; q < rows && q <= len; q++)
            cur[q] |= 1 << q;
        for (int c = 0; c < len; c++)
        begin
            a = cur[c];
            if (a != 0)
            begin
                pm  = pos_mask(c);
                hit = (sym < NUM_SYMBOLS) && pm[sym];
                if (hit)
                    nxt[c+1] |= a;
                else
                begin
                    e = (a << 1) & rmask;
                    nxt[c]   |= e;
                    nxt[c+1] |= e;
                end
            end
        end
        // deletion closure
        for (int c = 0; c < len; c++)
            nxt[c+1] |= (nxt[c] << 1) & rmask;
        for (int c = 0; c <= MAX_PATTERN; c++)
            cell_rows[c] = (c <= len) ? ROWS'(nxt[c]) : '0;

        fin      = nxt[len] & rmask;
        distance = rows;
        for (int q = rows - 1; q >= 0; q--)
            if ((fin >> q) & 1)
                distance = q;

        r = '0;
        if (distance < best)
        begin
            run_start = line_pos;
            best      = DIST_W'(distance);
            reported  = 1'b0;
        end
        else if (distance > best)
        begin
            if (reported)
            begin
                run_start = line_pos;
                best      = DIST_W'(distance);
            end
            else
            begin
                end_pos = (line_pos == POS_MAX) ? POS_MAX
                        : ((line_pos != 0) ? line_pos - 1'b1 : '0);
                r.match_found    = 1'b1;
                r.match_end      = end_pos;
                r.plateau_length = (end_pos >= run_start) ? end_pos - run_start : '0;
                r.match_distance = best[ERR_W-1:0];
                reported         = 1'b1;
            end
        end
        if (line_pos != POS_MAX)
            line_pos = line_pos + 1'b1;
        r.distance_now = DIST_W'(distance);
        return r;
    endfunction

    // mostly 0..3, sometimes "other", now and then an undefined code
    function automatic logic [SYM_W-1:0] random_base();
        int k;
        k = $urandom_range(0, 15);
        if (k < 12)
            return SYM_W'(k % 4);
        if (k < 14)
            return SYM_W'(4);
        return SYM_W'($urandom_range(5, SYM_CODES - 1));
    endfunction

    function automatic logic [SYM_W-1:0] base_for(input logic [MASK_BITS-1:0] m);
        int s;
        if (m == 0)
            return random_base();
        do
            s = $urandom_range(0, MASK_BITS - 1);
        while (!m[s]);
        return SYM_W'(s);
    endfunction

    // lots of single bases, some ambiguity codes, the odd empty position
    function automatic logic [2*MASK_REG_W-1:0] random_masks();
        logic [2*MASK_REG_W-1:0] m;
        int                      k;
        for (int p = 0; p < 2*POSITIONS_PER_REG; p++)
        begin
            k = $urandom_range(0, 9);
            if (k < 6)
                m[MASK_BITS*p +: MASK_BITS] = MASK_BITS'(1 << $urandom_range(0, 3));
            else if (k < 8)
                m[MASK_BITS*p +: MASK_BITS] = MASK_BITS'($urandom);
            else if (k == 8)
                m[MASK_BITS*p +: MASK_BITS] = '1;
            else
                m[MASK_BITS*p +: MASK_BITS] = MASK_BITS'($urandom_range(0, 1) ? 0 : $urandom);
        end
        return m;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (mismatch_count < PRINT_CAP)
            $display("%0t mismatch %s: expected %0h got %0h", $realtime, what, want, got);
        mismatch_count++;
    endtask

    task automatic send_base(input logic [SYM_W-1:0] sym, input logic ls);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        symbol     <= sym;
        line_start <= ls;
        do
            @(posedge clk);
        while (!in_ready);
        pending_reports.push_back(advance_levenshtein(sym, ls));
        bases_sent++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_pattern(input logic [MASK_REG_W-1:0] lo, input logic [MASK_REG_W-1:0] hi,
                                input logic [LEN_W-1:0] len, input logic [ERR_W-1:0] err);
        logic [MASK_REG_W-1:0] junk;
        junk = MASK_REG_W'({$urandom, $urandom});
        // upper data bits are don't-care for the narrow registers
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MASKS_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_MASKS_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= CFG_PATTERN_LENGTH;
        cfg_data  <= {junk[MASK_REG_W-1:LEN_W], len};
        @(posedge clk);
        cfg_index <= CFG_MAX_ERRORS;
        cfg_data  <= {junk[MASK_REG_W-1:ERR_W], err};
        @(posedge clk);
        cfg_we <= 1'b0;
        m_lo  = lo;
        m_hi  = hi;
        m_len = len;
        m_err = err;
    endtask

    // flank, mutated copy of the pattern, flank
    task automatic send_pattern_line(input logic fresh);
        int   n;
        logic ls;
        ls = fresh;
        n  = $urandom_range(0, 6);
        repeat (n)
        begin
            send_base(random_base(), ls);
            ls = 1'b0;
        end
        for (int p = 0; p < used_len(); p++)
        begin
            case ($urandom_range(0, 9))
                0: ; // deletion
                1:
                begin
                    send_base(random_base(), ls);
                    ls = 1'b0;
                end
                2:
                begin
                    send_base(random_base(), ls);
                    send_base(base_for(pos_mask(p)), 1'b0);
                    ls = 1'b0;
                end
                default:
                begin
                    send_base(base_for(pos_mask(p)), ls);
                    ls = 1'b0;
                end
            endcase
        end
        n = $urandom_range(0, 6);
        repeat (n) send_base(random_base(), 1'b0);
    endtask

    task automatic send_noise_line();
        int n;
        n = $urandom_range(1, 12);
        repeat (n) send_base(random_base(), $urandom_range(0, 7) == 0);
    endtask

    task automatic test_reset_defaults();
        for (int s = 0; s < SYM_CODES; s++)
            send_base(SYM_W'(s), s == 0 || s == 5);
        settle();
    endtask

    task automatic test_exact_match();
        logic [MASK_REG_W-1:0] acgt;
        acgt = '0;
        acgt[0 +: MASK_BITS]           = 5'h01;
        acgt[MASK_BITS +: MASK_BITS]   = 5'h02;
        acgt[2*MASK_BITS +: MASK_BITS] = 5'h04;
        acgt[3*MASK_BITS +: MASK_BITS] = 5'h08;
        load_pattern(acgt, '0, LEN_W'(4), ERR_W'(1));
        // G A C G T T T: exact hit then a rise
        send_base(SYM_W'(2), 1'b1);
        send_base(SYM_W'(0), 1'b0);
        send_base(SYM_W'(1), 1'b0);
        send_base(SYM_W'(2), 1'b0);
        send_base(SYM_W'(3), 1'b0);
        send_base(SYM_W'(3), 1'b0);
        send_base(SYM_W'(3), 1'b0);
        settle();
    endtask

    task automatic test_extremes();
        logic [MASK_REG_W-1:0] other_only;
        // all masks set, length above range, most errors
        load_pattern('1, '1, LEN_W'(31), ERR_W'(MAX_ERRORS));
        send_base(SYM_W'(4), 1'b1);
        send_base(SYM_W'(7), 1'b0);
        send_base(SYM_W'(0), 1'b0);
        send_base(SYM_W'(3), 1'b0);
        settle();
        // change within the line: length zero, errors above length
        other_only = '0;
        other_only[0 +: MASK_BITS] = 5'h10;
        load_pattern(other_only, '1, LEN_W'(0), ERR_W'(MAX_ERRORS));
        send_base(SYM_W'(4), 1'b0);
        send_base(SYM_W'(5), 1'b0);
        send_base(SYM_W'(6), 1'b0);
        send_base(SYM_W'(2), 1'b0);
        settle();
    endtask

    // one long line sent back to back
    task automatic test_long_line();
        logic [2*MASK_REG_W-1:0] m;
        m = random_masks();
        load_pattern(m[MASK_REG_W-1:0], m[2*MASK_REG_W-1:MASK_REG_W], LEN_W'(3), ERR_W'(1));
        idle_on = 1'b0;
        send_base(random_base(), 1'b1);
        repeat (150) send_base(random_base(), 1'b0);
        settle();
    endtask

    task automatic test_random_lines();
        logic [2*MASK_REG_W-1:0] m;
        logic [LEN_W-1:0]        len;
        logic [ERR_W-1:0]        err;
        int                      goal;
        int                      half;
        bit                      paused;
        for (int ph = 0; ph < 10; ph++)
        begin
            m = random_masks();
            case (ph)
                0:
                begin
                    len = LEN_W'(MAX_PATTERN);
                    err = ERR_W'(MAX_ERRORS);
                end
                1:
                begin
                    len = LEN_W'(1);
                    err = '0;
                end
                2:
                begin
                    len = '0;
                    err = ERR_W'(3);
                end
                3:
                begin
                    len = '1;
                    err = ERR_W'(MAX_ERRORS);
                end
                default:
                begin
                    len = LEN_W'($urandom_range(2, MAX_PATTERN));
                    if ($urandom_range(0, 5) == 0)
                        err = ERR_W'($urandom);
                    else
                        err = ERR_W'($urandom_range(0, (len - 1 > MAX_ERRORS) ?
                                                       MAX_ERRORS : len - 1));
                end
            endcase
            load_pattern(m[MASK_REG_W-1:0], m[2*MASK_REG_W-1:MASK_REG_W], len, err);
            // no idling over the closing phases
            idle_on = (ph < 8) && ($urandom_range(0, 3) != 0);
            goal    = bases_sent + 100;
            half    = bases_sent + 50;
            paused  = 1'b0;
            while (bases_sent < goal)
            begin
                if (!paused && bases_sent >= half)
                begin
                    settle();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 4) == 0)
                    send_noise_line();
                else
                    send_pattern_line($urandom_range(0, 9) != 0);
            end
            settle();
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
                report_mismatch("result with none pending", '0, '0);
            else
            begin
                want = pending_reports.pop_front();
                if (distance_now !== want.distance_now)
                    report_mismatch("distance_now", 32'(want.distance_now),
                                    32'(distance_now));
                if (match_found !== want.match_found)
                    report_mismatch("match_found", 32'(want.match_found),
                                    32'(match_found));
                if (match_end !== want.match_end)
                    report_mismatch("match_end", 32'(want.match_end), 32'(match_end));
                if (plateau_length !== want.plateau_length)
                    report_mismatch("plateau_length", 32'(want.plateau_length),
                                    32'(plateau_length));
                if (match_distance !== want.match_distance)
                    report_mismatch("match_distance", 32'(want.match_distance),
                                    32'(match_distance));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    initial
    begin
        while (stalled_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("approximate_dna_pattern_matcher_top_tb: FAIL");
        $finish;
    end

    initial
    begin
        reset_predictor();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        idle_on = 1'b1;
        test_reset_defaults();
        test_exact_match();
        test_extremes();
        test_long_line();
        test_random_lines();
        settle();
        if (mismatch_count == 0)
            $display("approximate_dna_pattern_matcher_top_tb: PASS");
        else
            $display("approximate_dna_pattern_matcher_top_tb: FAIL");
        $finish;
    end

endmodule
